/* sv/kce_pkg.sv */
// Package of the k-combination enumerator: field widths, register indexes
// and the payload types shared by the result interface and the top level.
// No dependencies.
package kce_pkg;

  localparam int ELEM_W    = 7;  // element and range_top width
  localparam int POS_W     = 4;  // position field width
  localparam int COUNT_W   = 5;  // choose_count width
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 7;  // widest configuration register

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_TOP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHOOSE_COUNT = 2'd1;

  typedef logic [ELEM_W-1:0]  elem_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [COUNT_W-1:0] count_t;

endpackage

/* sv/kce_in_if.sv */
// Request channel of the k-combination enumerator: valid/ready plus the
// restart flag. Depends on nothing.
interface kce_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

/* sv/kce_out_if.sv */
// Result channel of the k-combination enumerator: valid/ready plus one
// element of a combination. Depends on kce_pkg.
interface kce_out_if;
  logic           valid;
  logic           ready;
  kce_pkg::elem_t element;
  kce_pkg::pos_t  position;
  logic           last;
  logic           exhausted;

  modport source (output valid, output element, output position, output last,
                  output exhausted, input ready);
  modport sink   (input valid, input element, input position, input last,
                  input exhausted, output ready);
endinterface

/* sv/k_combination_enumerator_top.sv */
// Top level of the k-combination enumerator: control sequencer, config
// registers and output register around the combination RAM.
// Depends on kce_pkg, kce_in_if, kce_out_if and kce_ram.
//
//   Channel  Dir  Handshake          Carries
//   in_ch    in   valid/ready        restart
//   out_ch   out  valid/ready        element, position, last, exhausted
//   cfg_*    in   cfg_we (no wait)   cfg_index, cfg_data
//
// A restart writes and emits the values 1..k. An advance scans right to left (a
// read, then a compare that also reads the next entry), then emits each kept
// element through a RAM read and each refill value directly. An exhausted
// result follows the accept or a full scan that finds no move. Reset idles the
// sequencer, clears flags and output valid and sets config registers to 1; the
// RAM needs none. A stalled output holds the sequencer; the next request is
// taken once the last result of the previous one sits in the output register.
module k_combination_enumerator_top #(
  parameter int MAX_N = 64,
  parameter int MAX_K = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [kce_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kce_pkg::CFG_W-1:0]           cfg_data,
  kce_in_if.sink                              in_ch,
  kce_out_if.source                           out_ch
);
  localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_RD  = 3'd1;
  localparam logic [2:0] S_SCAN_CMP = 3'd2;
  localparam logic [2:0] S_EM_RD    = 3'd3;
  localparam logic [2:0] S_EM_OUT   = 3'd4;
  localparam logic [2:0] S_EXH      = 3'd5;

  logic [2:0]      state_r, state_nxt;
  kce_pkg::elem_t  range_top_r, range_top_nxt;
  kce_pkg::count_t choose_count_r, choose_count_nxt;
  logic            started_r, started_nxt;
  logic            finished_r, finished_nxt;
  kce_pkg::count_t p_r, p_nxt;        // scan position
  kce_pkg::count_t q_r, q_nxt;        // emit position
  kce_pkg::count_t piv_r, piv_nxt;    // first position that is rewritten
  kce_pkg::elem_t  val_r, val_nxt;    // next refill value
  kce_pkg::elem_t  base_r, base_nxt;  // n - k + 1

  logic            out_valid_r, out_valid_nxt;
  kce_pkg::elem_t  out_elem_r, out_elem_nxt;
  kce_pkg::pos_t   out_pos_r, out_pos_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_exh_r, out_exh_nxt;

  logic            ram_we, ram_re;
  logic [KW-1:0]   ram_waddr, ram_raddr;
  kce_pkg::elem_t  ram_wdata, ram_rdata;

  kce_pkg::elem_t  n_eff;
  logic            k_bad;
  logic [7:0]      base_full;
  logic            out_free;
  logic            out_load;
  logic            cfg_hit;
  kce_pkg::count_t q_inc;
  kce_pkg::count_t k_m1;

  kce_ram #(.WIDTH(kce_pkg::ELEM_W), .DEPTH(MAX_K)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign n_eff = (range_top_r > kce_pkg::ELEM_W'(MAX_N)) ? kce_pkg::ELEM_W'(MAX_N)
                                                           : range_top_r;
  assign k_bad = (choose_count_r == '0) ||
                 ({3'b000, choose_count_r} > 8'(MAX_K)) ||
                 ({2'b00, choose_count_r} > n_eff);
  assign base_full = {1'b0, n_eff} - {3'b000, choose_count_r} + 8'd1;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign q_inc     = q_r + 5'd1;
  assign k_m1      = choose_count_r - 5'd1;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.element   = out_elem_r;
  assign out_ch.position  = out_pos_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.exhausted = out_exh_r;

  // Scan reads only happen before any write of the request, and during
  // emission reads stay left of the pivot while writes stay at or right of
  // it, so the RAM never sees a read and a write of one entry together.
  always_comb begin
    state_nxt        = state_r;
    range_top_nxt    = range_top_r;
    choose_count_nxt = choose_count_r;
    started_nxt      = started_r;
    finished_nxt     = finished_r;
    p_nxt            = p_r;
    q_nxt            = q_r;
    piv_nxt          = piv_r;
    val_nxt          = val_r;
    base_nxt         = base_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_elem_nxt     = out_elem_r;
    out_pos_nxt      = out_pos_r;
    out_last_nxt     = out_last_r;
    out_exh_nxt      = out_exh_r;
    out_load         = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = KW'(q_r);
    ram_wdata        = val_r;
    ram_re           = 1'b0;
    ram_raddr        = KW'(p_r);
    cfg_hit          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          base_nxt = base_full[kce_pkg::ELEM_W-1:0];
          if (in_ch.restart || !started_r) begin
            started_nxt  = 1'b1;
            finished_nxt = k_bad;
            piv_nxt      = '0;
            val_nxt      = kce_pkg::ELEM_W'(1);
            q_nxt        = '0;
            state_nxt    = k_bad ? S_EXH : S_EM_OUT;
          end else if (finished_r || k_bad) begin
            finished_nxt = 1'b1;
            state_nxt    = S_EXH;
          end else begin
            p_nxt     = k_m1;
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if ({1'b0, ram_rdata} < ({1'b0, base_r} + {3'b000, p_r})) begin
          piv_nxt   = p_r;
          val_nxt   = ram_rdata + kce_pkg::ELEM_W'(1);
          q_nxt     = '0;
          state_nxt = (p_r == '0) ? S_EM_OUT : S_EM_RD;
        end else if (p_r == '0) begin
          finished_nxt = 1'b1;
          state_nxt    = S_EXH;
        end else begin
          p_nxt     = p_r - 5'd1;
          ram_re    = 1'b1;
          ram_raddr = KW'(p_r - 5'd1);
        end
      end
      S_EM_RD: begin
        ram_re    = 1'b1;
        ram_raddr = KW'(q_r);
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_valid_nxt = 1'b1;
          out_pos_nxt  = q_r[kce_pkg::POS_W-1:0];
          out_last_nxt = (q_r == k_m1);
          out_exh_nxt  = 1'b0;
          if (q_r < piv_r) begin
            out_elem_nxt = ram_rdata;
          end else begin
            out_elem_nxt = val_r;
            ram_we       = 1'b1;
            val_nxt      = val_r + kce_pkg::ELEM_W'(1);
          end
          if (q_r == k_m1) begin
            state_nxt = S_IDLE;
          end else begin
            q_nxt     = q_inc;
            state_nxt = (q_inc < piv_r) ? S_EM_RD : S_EM_OUT;
          end
        end
      end
      S_EXH: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_elem_nxt  = '0;
          out_pos_nxt   = '0;
          out_last_nxt  = 1'b1;
          out_exh_nxt   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        kce_pkg::REG_RANGE_TOP: begin
          range_top_nxt = cfg_data[kce_pkg::ELEM_W-1:0];
          cfg_hit       = 1'b1;
        end
        kce_pkg::REG_CHOOSE_COUNT: begin
          choose_count_nxt = cfg_data[kce_pkg::COUNT_W-1:0];
          cfg_hit          = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
    if (cfg_hit) begin
      started_nxt  = 1'b0;
      finished_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      range_top_r    <= kce_pkg::ELEM_W'(1);
      choose_count_r <= kce_pkg::COUNT_W'(1);
      started_r      <= 1'b0;
      finished_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      range_top_r    <= range_top_nxt;
      choose_count_r <= choose_count_nxt;
      started_r      <= started_nxt;
      finished_r     <= finished_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    piv_r      <= piv_nxt;
    val_r      <= val_nxt;
    base_r     <= base_nxt;
    out_elem_r <= out_elem_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
    out_exh_r  <= out_exh_nxt;
  end

  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write hit the same entry");

  a_exh_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_exh_r) |-> (out_last_r && (out_elem_r == '0)))
    else $error("exhausted result is not a lone zero item");

  a_finished_started: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> started_r)
    else $error("finished set without a started enumeration");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EM_OUT || state_r == S_EM_RD) |-> (q_r < choose_count_r))
    else $error("emit position beyond k");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last_nxt) |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after the last item");

endmodule

/* sv/kce_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Read data holds until the next read enable. No dependencies.
module kce_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]   waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]   raddr,
  output logic [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule
